// ===== rtl/core/itp_pkg.sv =====
// shared constants, types and character helpers of the infix to postfix converter
package itp_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 32;
	localparam int unsigned SYM_W = 8;

	localparam logic [SYM_W-1:0] SYM_LPAREN = 8'h28;
	localparam logic [SYM_W-1:0] SYM_RPAREN = 8'h29;
	localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
	localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_SLASH  = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_UC_A   = 8'h41;
	localparam logic [SYM_W-1:0] SYM_UC_Z   = 8'h5A;
	localparam logic [SYM_W-1:0] SYM_LC_A   = 8'h61;
	localparam logic [SYM_W-1:0] SYM_LC_Z   = 8'h7A;

	localparam logic [2:0] PREC_PAREN = 3'd4;
	localparam logic [2:0] PREC_POW   = 3'd3;
	localparam logic [2:0] PREC_MUL   = 3'd2;
	localparam logic [2:0] PREC_ADD   = 3'd1;
	localparam logic [2:0] PREC_NONE  = 3'd0;

	typedef logic [SYM_W-1:0] sym_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	function automatic logic [2:0] prec(input sym_t ch);
		logic [2:0] p;
		p = PREC_NONE;
		if (ch == SYM_LPAREN) begin
			p = PREC_PAREN;
		end else if (ch == SYM_CARET) begin
			p = PREC_POW;
		end else if (ch == SYM_STAR || ch == SYM_SLASH) begin
			p = PREC_MUL;
		end else if (ch == SYM_PLUS || ch == SYM_MINUS) begin
			p = PREC_ADD;
		end
		return p;
	endfunction

	function automatic logic is_letter(input sym_t ch);
		return (ch >= SYM_UC_A && ch <= SYM_UC_Z) || (ch >= SYM_LC_A && ch <= SYM_LC_Z);
	endfunction

endpackage

// ===== rtl/core/itp_cell.sv =====
// one stack cell: takes its neighbor's entry on push or pop, else holds
module itp_cell (
	input  logic          clk,
	input  logic          push,
	input  logic          pop,
	input  itp_pkg::sym_t from_left,
	input  itp_pkg::sym_t from_right,
	output itp_pkg::sym_t data_q
);

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= from_left;
		end else if (pop) begin
			data_q <= from_right;
		end
	end

endmodule

// ===== rtl/core/infix_to_postfix_converter.sv =====
// infix to postfix converter: operator stack as a row of shifting cells plus control
//
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+--------------------------------------------
// input    | symbol_valid | symbol_ready | symbol, end_of_expression
// result   | result_valid | result_ready | out_symbol, last_of_run, stack_overflow
//
// an input beat is taken only while idle, so a new symbol is not taken before the last one is through
// a letter is sent from the scan state once the result slot is free; an operator pops one stacked beat
// per cycle while the result slot is free, and then is pushed or discarded
// the end of an expression flushes one stack entry per cycle, top first
// a stalled result beat holds the scan and the flush; reset empties the stack and clears the flag
module infix_to_postfix_converter #(
	parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          symbol_valid,
	output logic          symbol_ready,
	input  itp_pkg::sym_t symbol,
	input  logic          end_of_expression,
	output logic          result_valid,
	input  logic          result_ready,
	output itp_pkg::sym_t out_symbol,
	output logic          last_of_run,
	output logic          stack_overflow
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	itp_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            ovf_q, ovf_d;
	itp_pkg::sym_t   ch_q;
	logic            eoe_q;
	logic            res_valid_q;
	itp_pkg::sym_t   res_sym_q;
	logic            res_last_q, res_ovf_q;

	logic            push, pop, emit, emit_last, slot_free, accept;
	itp_pkg::sym_t   emit_sym;
	itp_pkg::sym_t   cell_data [STACK_DEPTH];
	itp_pkg::sym_t   top, second;
	logic [2:0]      p_ch;
	logic            top_pops, next_pops;
	logic [CW-1:0]   c1, c2;

	// stack row, top in cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		itp_pkg::sym_t left_in, right_in;
		if (i == 0) begin : g_first
			assign left_in = ch_q;
		end else begin : g_mid
			assign left_in = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = cell_data[i+1];
		end
		itp_cell u_cell (
			.clk        (clk),
			.push       (push),
			.pop        (pop),
			.from_left  (left_in),
			.from_right (right_in),
			.data_q     (cell_data[i])
		);
	end

	assign top = cell_data[0];
	assign second = cell_data[1];
	assign slot_free = !res_valid_q || result_ready;
	assign symbol_ready = (state_q == itp_pkg::ST_IDLE);
	assign accept = symbol_valid && symbol_ready;
	assign p_ch = itp_pkg::prec(ch_q);
	assign top_pops = (count_q != '0) && (top != itp_pkg::SYM_LPAREN)
		&& (p_ch <= itp_pkg::prec(top));
	assign next_pops = (count_q > CNT_ONE) && (second != itp_pkg::SYM_LPAREN)
		&& (p_ch <= itp_pkg::prec(second));

	// stack depth after the current pop and the push or discard that follows
	always_comb begin
		c1 = count_q - CNT_ONE;
		if (ch_q == itp_pkg::SYM_RPAREN) begin
			c2 = (c1 != '0 && second == itp_pkg::SYM_LPAREN) ? c1 - CNT_ONE : c1;
		end else begin
			c2 = c1 + CNT_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itp_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
		end
	end

	always_comb begin
		logic [CW-1:0] c_new;
		state_d = state_q;
		count_d = count_q;
		ovf_d = ovf_q;
		push = 1'b0;
		pop = 1'b0;
		emit = 1'b0;
		emit_sym = top;
		emit_last = 1'b0;
		c_new = count_q;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = itp_pkg::ST_SCAN;
				end
			end
			itp_pkg::ST_SCAN: begin
				if (itp_pkg::is_letter(ch_q)) begin
					if (slot_free) begin
						emit = 1'b1;
						emit_sym = ch_q;
						emit_last = !(eoe_q && count_q != '0);
						if (eoe_q && count_q != '0) begin
							state_d = itp_pkg::ST_FLUSH;
						end else begin
							state_d = itp_pkg::ST_IDLE;
							if (eoe_q) begin
								ovf_d = 1'b0;
							end
						end
					end
				end else if (top_pops) begin
					if (slot_free) begin
						emit = 1'b1;
						pop = 1'b1;
						count_d = c1;
						emit_last = !next_pops && !(eoe_q && c2 != '0);
					end
				end else begin
					if (ch_q == itp_pkg::SYM_RPAREN) begin
						if (count_q != '0 && top == itp_pkg::SYM_LPAREN) begin
							pop = 1'b1;
							c_new = count_q - CNT_ONE;
						end
					end else if (count_q != CNT_FULL) begin
						push = 1'b1;
						c_new = count_q + CNT_ONE;
					end else begin
						ovf_d = 1'b1;
					end
					count_d = c_new;
					if (eoe_q && c_new != '0) begin
						state_d = itp_pkg::ST_FLUSH;
					end else begin
						state_d = itp_pkg::ST_IDLE;
						if (eoe_q) begin
							ovf_d = 1'b0;
						end
					end
				end
			end
			itp_pkg::ST_FLUSH: begin
				if (slot_free) begin
					emit = 1'b1;
					pop = 1'b1;
					count_d = c1;
					emit_last = (count_q == CNT_ONE);
					if (count_q == CNT_ONE) begin
						state_d = itp_pkg::ST_IDLE;
						ovf_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = itp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= symbol;
			eoe_q <= end_of_expression;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_sym_q <= emit_sym;
			res_last_q <= emit_last;
			res_ovf_q <= (state_q == itp_pkg::ST_FLUSH) ? ovf_q : ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign out_symbol = res_sym_q;
	assign last_of_run = res_last_q;
	assign stack_overflow = res_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("stack count beyond depth");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itp_pkg::ST_FLUSH |-> count_q != '0)
		else $error("flush with empty stack");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("push and pop together");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == itp_pkg::ST_SCAN)
		else $error("accepted beat not scanned");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("result overwritten while stalled");

endmodule

// ===== tb/postfix_checker.sv =====
// scoreboard for the infix to postfix converter: predicts every postfix beat and compares
module postfix_checker #(
	parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          symbol_valid,
	input  logic          symbol_ready,
	input  itp_pkg::sym_t symbol,
	input  logic          end_of_expression,
	input  logic          result_valid,
	input  logic          result_ready,
	input  itp_pkg::sym_t out_symbol,
	input  logic          last_of_run,
	input  logic          stack_overflow,
	output int            mismatches,
	output int            pending_beats,
	output int            checked_beats,
	output int            flagged_beats,
	output int            closed_exprs
);
	timeunit 1ns;
	timeprecision 1ps;
	import itp_pkg::*;

	typedef struct packed {
		sym_t sym;
		logic last;
		logic ovf;
	} postfix_beat_t;

	sym_t          op_stack [STACK_DEPTH];
	int unsigned   depth_used = 0;
	bit            sticky_overflow = 1'b0;
	postfix_beat_t postfix_q [$];

	int miss_count = 0;
	int queued = 0;
	int checked_count = 0;
	int flagged_count = 0;
	int closed_count = 0;

	assign mismatches    = miss_count;
	assign pending_beats = queued;
	assign checked_beats = checked_count;
	assign flagged_beats = flagged_count;
	assign closed_exprs  = closed_count;

	function automatic int unsigned rank_of(input sym_t ch);
		if (ch == SYM_LPAREN) return 4;
		if (ch == SYM_CARET) return 3;
		if (ch == SYM_STAR || ch == SYM_SLASH) return 2;
		if (ch == SYM_PLUS || ch == SYM_MINUS) return 1;
		return 0;
	endfunction

	function automatic bit is_alpha(input sym_t ch);
		return (ch >= SYM_UC_A && ch <= SYM_UC_Z) || (ch >= SYM_LC_A && ch <= SYM_LC_Z);
	endfunction

	task automatic convert_symbol(input sym_t ch, input logic eoe);
		sym_t          run [$];
		int unsigned   r;
		postfix_beat_t b;
		if (is_alpha(ch)) begin
			run.push_back(ch);
		end else begin
			r = rank_of(ch);
			while (depth_used > 0 && op_stack[depth_used-1] != SYM_LPAREN &&
			       r <= rank_of(op_stack[depth_used-1])) begin
				depth_used--;
				run.push_back(op_stack[depth_used]);
			end
			if (ch == SYM_RPAREN) begin
				if (depth_used > 0 && op_stack[depth_used-1] == SYM_LPAREN)
					depth_used--;
			end else if (depth_used < STACK_DEPTH) begin
				op_stack[depth_used] = ch;
				depth_used++;
			end else begin
				sticky_overflow = 1'b1;
			end
		end
		if (eoe) begin
			while (depth_used > 0) begin
				depth_used--;
				run.push_back(op_stack[depth_used]);
			end
		end
		foreach (run[i]) begin
			b.sym  = run[i];
			b.last = (i == run.size() - 1);
			b.ovf  = sticky_overflow;
			postfix_q.push_back(b);
		end
		if (eoe)
			sticky_overflow = 1'b0;
	endtask

	task automatic note_mismatch(input string msg);
		miss_count++;
		if (miss_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		postfix_beat_t want;
		if (arst_n) begin
			// an output beat always belongs to an earlier input beat, so check first
			if (result_valid && result_ready) begin
				checked_count++;
				if (postfix_q.size() == 0) begin
					note_mismatch($sformatf("unexpected beat: sym %02h last %0b ovf %0b",
						out_symbol, last_of_run, stack_overflow));
				end else begin
					want = postfix_q.pop_front();
					if (want.ovf)
						flagged_count++;
					if (out_symbol !== want.sym || last_of_run !== want.last ||
					    stack_overflow !== want.ovf)
						note_mismatch($sformatf(
							"mismatch: expected sym %02h last %0b ovf %0b, got sym %02h last %0b ovf %0b",
							want.sym, want.last, want.ovf,
							out_symbol, last_of_run, stack_overflow));
				end
			end
			if (symbol_valid && symbol_ready) begin
				convert_symbol(symbol, end_of_expression);
				if (end_of_expression)
					closed_count++;
			end
			queued = postfix_q.size();
		end
	end

endmodule

// ===== tb/infix_to_postfix_converter_tb.sv =====
// testbench top for the infix to postfix converter: stimulus, handshake pacing and verdict
module infix_to_postfix_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import itp_pkg::*;

	localparam int unsigned RESET_CYCLES     = 11;
	localparam int unsigned RANDOM_ITEMS     = 346;
	localparam int unsigned DIRECTED_ITEMS   = 24;
	localparam int unsigned LONG_HOLD        = 250;
	localparam int unsigned HOLD_AFTER_BEATS = 40;
	localparam int unsigned TAIL_CYCLES      = 64;
	localparam int unsigned STALL_LIMIT      = 2000;

	typedef struct {
		sym_t sym;
		logic eoe;
	} infix_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic symbol_valid = 1'b0;
	logic symbol_ready;
	sym_t symbol = '0;
	logic end_of_expression = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	sym_t out_symbol;
	logic last_of_run;
	logic stack_overflow;
	logic quiet = 1'b0;

	int mismatches;
	int pending_beats;
	int checked_beats;
	int flagged_beats;
	int closed_exprs;
	int unsigned stalled_cycles = 0;
	infix_char_t char_q [$];

	infix_to_postfix_converter dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.symbol_valid      (symbol_valid),
		.symbol_ready      (symbol_ready),
		.symbol            (symbol),
		.end_of_expression (end_of_expression),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.out_symbol        (out_symbol),
		.last_of_run       (last_of_run),
		.stack_overflow    (stack_overflow)
	);

	postfix_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.symbol_valid      (symbol_valid),
		.symbol_ready      (symbol_ready),
		.symbol            (symbol),
		.end_of_expression (end_of_expression),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.out_symbol        (out_symbol),
		.last_of_run       (last_of_run),
		.stack_overflow    (stack_overflow),
		.mismatches        (mismatches),
		.pending_beats     (pending_beats),
		.checked_beats     (checked_beats),
		.flagged_beats     (flagged_beats),
		.closed_exprs      (closed_exprs)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((symbol_valid && symbol_ready) || (result_valid && result_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", stalled_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic add_char(input sym_t ch, input logic eoe);
		infix_char_t c;
		c.sym = ch;
		c.eoe = eoe;
		char_q.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(sym_t'(s[i]), i == s.len() - 1);
	endtask

	function automatic sym_t any_letter();
		if ($urandom_range(0, 1))
			return sym_t'($urandom_range(SYM_UC_A, SYM_UC_Z));
		return sym_t'($urandom_range(SYM_LC_A, SYM_LC_Z));
	endfunction

	function automatic sym_t any_operator();
		case ($urandom_range(0, 4))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_STAR;
			3: return SYM_SLASH;
			default: return SYM_CARET;
		endcase
	endfunction

	function automatic sym_t any_symbol();
		case ($urandom_range(0, 4))
			0: return SYM_LPAREN;
			1: return SYM_RPAREN;
			2: return any_letter();
			3: return any_operator();
			default: return sym_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic gen_expr(input int level);
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				add_char(any_operator(), 1'b0);
			if (level > 0 && $urandom_range(0, 3) == 0) begin
				add_char(SYM_LPAREN, 1'b0);
				gen_expr(level - 1);
				add_char(SYM_RPAREN, 1'b0);
			end else begin
				add_char(any_letter(), 1'b0);
			end
		end
	endtask

	// nesting deeper than the stack, closed by a letter that flushes it all
	task automatic gen_deep();
		repeat ($urandom_range(33, 40))
			add_char(SYM_LPAREN, 1'b0);
		add_char(any_letter(), 1'b1);
	endtask

	initial begin : sink
		int unsigned stall_left;
		int unsigned beats_taken;
		bit          held;
		stall_left = 0;
		beats_taken = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				beats_taken++;
			if (!held && beats_taken >= HOLD_AFTER_BEATS) begin
				held = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int unsigned quiet_from;
		int          kind;
		int          len;
		// operator mix, unmatched close on empty stack, odd bytes, left-to-right power
		add_text("A*(b+Z)^z-c/d");
		add_text(")");
		add_char(8'h00, 1'b0);
		add_char(8'hFF, 1'b0);
		add_text("7 (");
		add_text("a^b^c");
		gen_deep();
		while (char_q.size() < RANDOM_ITEMS + DIRECTED_ITEMS) begin
			kind = $urandom_range(0, 29);
			if (kind < 18) begin
				gen_expr(3);
				char_q[char_q.size() - 1].eoe = 1'b1;
			end else if (kind < 23) begin
				len = $urandom_range(1, 6);
				repeat (len)
					add_char(sym_t'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end else if (kind < 29) begin
				len = $urandom_range(2, 10);
				repeat (len)
					add_char(any_symbol(), 1'b0);
				char_q[char_q.size() - 1].eoe = 1'($urandom_range(0, 1));
			end else begin
				gen_deep();
			end
		end
		quiet_from = char_q.size() * 85 / 100;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (char_q[i]) begin
			if (i >= quiet_from)
				quiet <= 1'b1;
			if (i < quiet_from && $urandom_range(0, 5) == 0) begin
				symbol_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			symbol_valid      <= 1'b1;
			symbol            <= char_q[i].sym;
			end_of_expression <= char_q[i].eoe;
			@(posedge clk);
			while (!symbol_ready) @(posedge clk);
		end
		symbol_valid <= 1'b0;
		while (pending_beats != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d infix beats, checked %0d postfix beats over %0d closed expressions",
			char_q.size(), checked_beats, closed_exprs);
		$display("%0d beats carried the overflow flag; receiver held off once for %0d cycles",
			flagged_beats, LONG_HOLD);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
